[design/glyph_row_pixel_expander_defines.svh]
// assertion macros used by the checker file
`ifndef GLYPH_ROW_PIXEL_EXPANDER_DEFINES_SVH
`define GLYPH_ROW_PIXEL_EXPANDER_DEFINES_SVH

// property checked on every clock edge outside reset
`define GPX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define GPX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/gpx_pkg.sv]
// types and constants of the glyph row pixel expander
package gpx_pkg;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;

  localparam logic [1:0] REG_FONT_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FONT_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FG_COLOUR   = 2'd2;
  localparam logic [1:0] REG_BG_COLOUR   = 2'd3;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_RENDER = 1'b1;

  localparam logic [7:0]  FIRST_CODE = 8'd32;
  localparam logic [4:0]  MAX_WIDTH  = 5'd23;
  localparam int          BYTE_BITS  = 8;

  localparam logic [4:0]  RST_FONT_WIDTH  = 5'd8;
  localparam logic [5:0]  RST_FONT_HEIGHT = 6'd16;
  localparam logic [15:0] RST_FG_COLOUR   = 16'hFFFF;
  localparam logic [15:0] RST_BG_COLOUR   = 16'h0000;

  typedef struct packed {
    logic        kind;
    logic [11:0] font_addr;
    logic [7:0]  font_byte;
    logic [7:0]  char_code;
    logic [4:0]  glyph_row;
  } in_item_t;

  typedef struct packed {
    logic [15:0] colour;
    logic        last;
    logic        bad_request;
  } out_item_t;

endpackage

[design/glyph_row_pixel_expander.sv]
// character generator: font memory load and glyph row to rgb565 pixel expansion
// throughput: one pixel per cycle while out_ready does not stall the output; a good render
//   request holds the fetch stage until its row bytes are read and the pixel stage until
//   all its pixels are shifted out, while a load only writes the font memory
// reset: synchronous, clears stage valids and counters and restores the config
//   registers to width 8, height 16, fg 0xffff, bg 0; font memory is not cleared
module glyph_row_pixel_expander #(
  parameter int FONT_BYTES     = 4096,
  parameter int MAX_GLYPH_ROWS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  gpx_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output gpx_pkg::out_item_t          out_data,
  input  logic                        cfg_we,
  input  logic [gpx_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [gpx_pkg::CFG_DW-1:0]  cfg_data
);
  import gpx_pkg::*;

  // memory address, clamped height and glyph row index widths
  localparam int AW = $clog2(FONT_BYTES);
  localparam int HW = $clog2(MAX_GLYPH_ROWS + 1);
  localparam int GW = 8 + HW;
  localparam int BW = GW + 2;

  // config registers
  logic [4:0]  font_width;
  logic [5:0]  font_height;
  logic [15:0] fg_colour;
  logic [15:0] bg_colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      font_width  <= RST_FONT_WIDTH;
      font_height <= RST_FONT_HEIGHT;
      fg_colour   <= RST_FG_COLOUR;
      bg_colour   <= RST_BG_COLOUR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FONT_WIDTH:  font_width  <= cfg_data[4:0];
        REG_FONT_HEIGHT: font_height <= cfg_data[5:0];
        REG_FG_COLOUR:   fg_colour   <= cfg_data;
        REG_BG_COLOUR:   bg_colour   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // stage handshakes: each stage is free when empty or leaving
  // ---------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s1_free, s2_free, s3_free, s4_free, s5_free;
  logic s3_fin, s3_move, emit, s4_done;

  // stage 1: input register
  in_item_t s1_item;

  // stage 2: glyph row index
  logic          s2_load;
  logic [11:0]   s2_addr;
  logic [7:0]    s2_byte;
  logic [GW-1:0] s2_gidx;
  logic [1:0]    s2_bpr;
  logic [4:0]    s2_w;
  logic          s2_bad;

  // stage 3: byte fetch
  logic          s3_load;
  logic          s3_wr_ok;
  logic [AW-1:0] s3_waddr;
  logic [7:0]    s3_byte;
  logic [AW-1:0] s3_base;
  logic [1:0]    s3_nb;
  logic [4:0]    s3_w;
  logic          s3_bad;
  logic [1:0]    s3_fcnt;
  logic [15:0]   s3_rowbuf;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic [23:0]   s3_word;

  // stage 4: pixel shifter
  logic [23:0]   s4_word;
  logic [4:0]    s4_w;
  logic          s4_bad;
  logic [4:0]    s4_pcnt;

  // font memory
  logic [7:0]    font_mem [FONT_BYTES];
  logic [7:0]    mem_q;

  assign s5_free  = !out_valid || out_ready;
  assign emit     = s4_valid && s5_free;
  assign s4_done  = emit && (s4_pcnt == (s4_w - 5'd1));
  assign s4_free  = !s4_valid || s4_done;
  // loads and rejected rows finish at once, good rows after the last byte lands
  assign s3_fin   = s3_valid && (s3_load || s3_bad || (s3_fcnt == s3_nb));
  assign s3_move  = s3_fin && (s3_load || s4_free);
  assign s3_free  = !s3_valid || s3_move;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s2_free;
  assign in_ready = s1_free;

  // ---------------------------------------------------------------
  // stage 1 -> 2: clamp config, check code and row, glyph row index
  // ---------------------------------------------------------------
  logic [4:0]    s1_w;
  logic [HW-1:0] s1_h;
  logic [7:0]    s1_code_off;
  logic [GW-1:0] s1_gidx;
  logic          s1_bad;

  always_comb begin
    if (font_width == 5'd0) begin
      s1_w = 5'd1;
    end else if (font_width > MAX_WIDTH) begin
      s1_w = MAX_WIDTH;
    end else begin
      s1_w = font_width;
    end
    if (32'(font_height) > 32'(MAX_GLYPH_ROWS)) begin
      s1_h = HW'(MAX_GLYPH_ROWS);
    end else begin
      s1_h = HW'(font_height);
    end
    s1_code_off = s1_item.char_code - FIRST_CODE;
    s1_gidx     = GW'(s1_code_off) * GW'(s1_h) + GW'(s1_item.glyph_row);
    s1_bad      = (s1_item.char_code < FIRST_CODE) ||
                  (32'(s1_item.glyph_row) >= 32'(s1_h));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2_load <= (s1_item.kind == KIND_LOAD);
      s2_addr <= s1_item.font_addr;
      s2_byte <= s1_item.font_byte;
      s2_gidx <= s1_gidx;
      s2_bpr  <= 2'(s1_w >> 3) + 2'd1;
      s2_w    <= s1_w;
      s2_bad  <= s1_bad;
    end
  end

  // ---------------------------------------------------------------
  // stage 2 -> 3: byte address of the row and range check of its end
  // ---------------------------------------------------------------
  logic [4:0]    s2_wm1;
  logic [1:0]    s2_nb;
  logic [BW-1:0] s2_base;
  logic [31:0]   s2_end;
  logic          s2_bad_all;

  always_comb begin
    s2_wm1     = s2_w - 5'd1;
    s2_nb      = 2'(s2_wm1 >> 3) + 2'd1;
    s2_base    = BW'(s2_gidx) * BW'(s2_bpr);
    s2_end     = 32'(s2_base) + 32'(s2_nb) - 32'd1;
    s2_bad_all = s2_bad || (s2_end >= 32'(FONT_BYTES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s3_fcnt  <= 2'd0;
    end else if (s3_free) begin
      s3_valid <= s2_valid;
      s3_fcnt  <= 2'd0;
    end else if (rd_en) begin
      s3_fcnt  <= s3_fcnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free && s2_valid) begin
      s3_load  <= s2_load;
      s3_wr_ok <= 32'(s2_addr) < 32'(FONT_BYTES);
      s3_waddr <= AW'(s2_addr);
      s3_byte  <= s2_byte;
      s3_base  <= AW'(s2_base);
      s3_nb    <= s2_nb;
      s3_w     <= s2_w;
      s3_bad   <= s2_bad_all;
    end
  end

  // ---------------------------------------------------------------
  // stage 3: one memory port, a load writes once, a good row reads
  // its bytes one per cycle; each read is registered, so its byte lands in mem_q later
  // ---------------------------------------------------------------
  assign rd_en   = s3_valid && !s3_load && !s3_bad && (s3_fcnt < s3_nb);
  assign wr_en   = s3_valid && s3_load && s3_wr_ok;
  assign rd_addr = s3_base + AW'(s3_fcnt);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      font_mem[s3_waddr] <= s3_byte;
    end
    if (rd_en) begin
      mem_q <= font_mem[rd_addr];
    end
  end

  // park earlier bytes while the next read is issued
  always_ff @(posedge clk) begin
    if (rd_en && (s3_fcnt == 2'd1)) begin
      s3_rowbuf[15:8] <= mem_q;
    end
    if (rd_en && (s3_fcnt == 2'd2)) begin
      s3_rowbuf[7:0] <= mem_q;
    end
  end

  // row bits msb first, first byte on top
  always_comb begin
    case (s3_nb)
      2'd1:    s3_word = {mem_q, 16'h0000};
      2'd2:    s3_word = {s3_rowbuf[15:8], mem_q, 8'h00};
      default: s3_word = {s3_rowbuf, mem_q};
    endcase
  end

  // ---------------------------------------------------------------
  // stage 4: unless the output stalls, shift out one pixel per cycle
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      s4_pcnt  <= 5'd0;
    end else if (s4_free) begin
      s4_valid <= s3_move && !s3_load;
      s4_pcnt  <= 5'd0;
    end else if (emit) begin
      s4_pcnt  <= s4_pcnt + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_free && s3_move && !s3_load) begin
      s4_word <= s3_word;
      s4_w    <= s3_w;
      s4_bad  <= s3_bad;
    end else if (emit) begin
      s4_word <= {s4_word[22:0], 1'b0};
    end
  end

  // ---------------------------------------------------------------
  // stage 5: output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s5_free) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.colour      <= (!s4_bad && s4_word[23]) ? fg_colour : bg_colour;
      out_data.last        <= (s4_pcnt == (s4_w - 5'd1));
      out_data.bad_request <= s4_bad;
    end
  end

endmodule

[design/gpx_checker.sv]
// port-level checker for the glyph row pixel expander, with its bind
`include "glyph_row_pixel_expander_defines.svh"

module gpx_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input gpx_pkg::out_item_t out_data
);
  import gpx_pkg::*;

  // a stalled pixel stays offered
  `GPX_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "out_valid dropped while stalled")

  // a stalled pixel keeps its payload
  `GPX_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_data), "out_data changed while stalled")

  // the pipeline is empty and open right after reset
  `GPX_ASSERT_ALWAYS(a_rst_empty, rst |=> in_ready && !out_valid, "not empty after reset")

  // no request can reach the output before it has passed the stages after reset
  `GPX_ASSERT_ALWAYS(a_min_latency, rst |=> !out_valid [*2], "pixel too soon after reset")

endmodule

bind glyph_row_pixel_expander gpx_checker u_gpx_checker (.*);

[tb/glyph_row_pixel_expander_tb.sv]
// self-checking testbench for the glyph row pixel expander
`timescale 1ns / 1ps

module glyph_row_pixel_expander_tb;
  import gpx_pkg::*;

  localparam int FONT_BYTES     = 4096;
  localparam int MAX_GLYPH_ROWS = 32;
  // padded margin above the worst first-pixel latency
  localparam int DRAIN_CYCLES   = 16;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int PHASES         = 9;
  localparam int MIX_PER_PHASE  = 19;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // request side
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data  = '0;

  // pixel side
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // register write port
  logic                cfg_we    = 1'b0;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]   cfg_data  = '0;

  // shadow copy of the register file, updated when a write is issued
  logic [4:0]  cfg_width  = RST_FONT_WIDTH;
  logic [5:0]  cfg_height = RST_FONT_HEIGHT;
  logic [15:0] cfg_fg     = RST_FG_COLOUR;
  logic [15:0] cfg_bg     = RST_BG_COLOUR;

  // font memory as seen by accepted load requests
  logic [7:0] font_shadow [FONT_BYTES];
  // bytes that some queued load request will have written, used so that
  // no in-range render ever reads a never-written byte
  bit         font_loaded [FONT_BYTES];

  in_item_t  request_q [$];
  out_item_t pixel_q   [$];

  int unsigned requests_queued   = 0;
  int unsigned requests_accepted = 0;
  int unsigned render_count      = 0;
  int unsigned load_count        = 0;
  int unsigned rejected_rows     = 0;
  int unsigned pixels_checked    = 0;
  int unsigned mismatches        = 0;
  int unsigned cycles            = 0;
  int unsigned settings_used     = 1;

  // idle pressure knobs, changed per phase from the stimulus block
  int unsigned send_idle_pct = 15;
  int unsigned recv_stall_pct = 15;
  bit          calm_tail = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;

  glyph_row_pixel_expander dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // glyph row geometry under the current register settings: clamped width,
  // clamped height, bytes per row, reject flag and first byte address
  function automatic void row_geometry(input logic [7:0] code, input logic [4:0] row,
                                       output int unsigned w, output int unsigned h,
                                       output int unsigned bpr, output bit bad,
                                       output int unsigned base);
    w = cfg_width;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = cfg_height;
    if (h > MAX_GLYPH_ROWS) h = MAX_GLYPH_ROWS;
    bpr = w / BYTE_BITS + 1;
    base = 0;
    bad = (code < FIRST_CODE) || (row >= h);
    if (!bad) begin
      base = (code - FIRST_CODE) * h * bpr + row * bpr;
      // only the bytes that hold pixels have to lie inside the memory
      if (base + (w - 1) / BYTE_BITS >= FONT_BYTES) bad = 1'b1;
    end
  endfunction

  // expected pixels of one accepted request; loads only update the shadow
  task automatic expand_glyph_row(input in_item_t req);
    int unsigned w, h, bpr, base, i;
    bit          bad;
    logic [7:0]  bits;
    out_item_t   px;
    if (req.kind == KIND_LOAD) begin
      font_shadow[req.font_addr] = req.font_byte;
      load_count++;
    end else begin
      row_geometry(req.char_code, req.glyph_row, w, h, bpr, bad, base);
      render_count++;
      if (bad) rejected_rows++;
      for (i = 0; i < w; i++) begin
        px.colour = cfg_bg;
        if (!bad) begin
          bits = font_shadow[base + i / BYTE_BITS];
          // msb first within each byte
          if (bits[7 - (i % BYTE_BITS)]) px.colour = cfg_fg;
        end
        px.last        = (i + 1 == w);
        px.bad_request = bad;
        pixel_q = {pixel_q, px};
      end
    end
  endtask

  // bitmap content: solid, empty and random rows all matter
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_load(input logic [11:0] addr, input logic [7:0] value);
    in_item_t req;
    req.kind      = KIND_LOAD;
    req.font_addr = addr;
    req.font_byte = value;
    // render fields are don't-care here, keep them moving
    req.char_code = 8'($urandom);
    req.glyph_row = 5'($urandom);
    request_q = {request_q, req};
    font_loaded[addr] = 1'b1;
    requests_queued++;
  endtask

  // render request, preceded by loads for any byte of the row not yet
  // written; with refresh set the whole row gets new content first
  task automatic queue_render(input logic [7:0] code, input logic [4:0] row,
                              input bit refresh);
    int unsigned w, h, bpr, base, j;
    bit          bad;
    in_item_t    req;
    row_geometry(code, row, w, h, bpr, bad, base);
    if (!bad) begin
      for (j = 0; j < bpr; j++) begin
        if (base + j < FONT_BYTES && (refresh || !font_loaded[base + j]))
          queue_load(12'(base + j), pick_byte());
      end
    end
    req.kind      = KIND_RENDER;
    req.font_addr = 12'($urandom);
    req.font_byte = 8'($urandom);
    req.char_code = code;
    req.glyph_row = row;
    request_q = {request_q, req};
    requests_queued++;
  endtask

  // mostly well-formed glyph rows up to and across the memory boundary,
  // the rest random render requests and stray loads anywhere in the memory
  task automatic queue_random_mix(input int unsigned count);
    int unsigned w, h, bpr, base, span, n;
    bit          bad;
    for (n = 0; n < count; n++) begin
      row_geometry(FIRST_CODE, 5'd0, w, h, bpr, bad, base);
      case ($urandom_range(99)) inside
        [0:59]: begin
          if (h == 0) begin
            queue_render(8'($urandom), 5'($urandom), 1'b0);
          end else begin
            // span reaches one glyph past the last one that fits
            span = FONT_BYTES / (h * bpr);
            if (span > 255 - FIRST_CODE) span = 255 - FIRST_CODE;
            queue_render(8'(FIRST_CODE + $urandom_range(span)),
                         5'($urandom_range(h - 1)), $urandom_range(9) == 0);
          end
        end
        [60:74]: queue_render(8'($urandom), 5'($urandom), 1'b0);
        default: queue_load(12'($urandom), pick_byte());
      endcase
    end
  endtask

  // register write, only issued while the block is idle
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_FONT_WIDTH:  cfg_width  = value[4:0];
      REG_FONT_HEIGHT: cfg_height = value[5:0];
      REG_FG_COLOUR:   cfg_fg     = value;
      REG_BG_COLOUR:   cfg_bg     = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // every request accepted, every pixel seen, then let loads settle
  task automatic wait_drained();
    while (requests_accepted != requests_queued || pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // request driver: new request only when the slot is empty or just taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expand_glyph_row(in_data);
        requests_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0 && !calm_tail &&
                     $urandom_range(99) < send_idle_pct) begin
          // start an idle burst of random length
          send_gap = $urandom_range(11);
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          in_data  <= request_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // pixel monitor with random back-pressure
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        pixels_checked++;
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel: colour %h last %b bad_request %b",
                 out_data.colour, out_data.last, out_data.bad_request);
          mismatches++;
        end else begin
          want = pixel_q.pop_front();
          if (out_data.colour !== want.colour) begin
            $error("colour: expected %h, got %h", want.colour, out_data.colour);
            mismatches++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_data.last);
            mismatches++;
          end
          if (out_data.bad_request !== want.bad_request) begin
            $error("bad_request: expected %b, got %b", want.bad_request,
                   out_data.bad_request);
            mismatches++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (!calm_tail && $urandom_range(99) < recv_stall_pct) begin
        recv_gap = $urandom_range(11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still expected", cycles, pixel_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [4:0]  wv;
    logic [5:0]  hv;
    logic [15:0] fgv, bgv;
    int          ph;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset settings: width 8, height 16, two bytes per row
    queue_load(12'h000, 8'hA5);
    queue_load(12'h001, 8'h00);
    queue_render(FIRST_CODE, 5'd0, 1'b0);
    queue_load(12'h002, 8'hFF);
    queue_load(12'h003, 8'hFF);
    queue_render(FIRST_CODE, 5'd1, 1'b0);
    queue_load(12'h004, 8'h00);
    queue_load(12'h005, 8'h00);
    queue_render(FIRST_CODE, 5'd2, 1'b0);
    // code below the first glyph
    queue_render(8'd0, 5'd0, 1'b0);
    queue_render(8'd31, 5'd31, 1'b0);
    // row at or past the glyph height
    queue_render(8'd33, 5'd16, 1'b0);
    queue_render(FIRST_CODE, 5'd31, 1'b0);
    // last glyph row that still fits ends on the top two bytes
    queue_load(12'hFFE, 8'h01);
    queue_load(12'hFFF, 8'hFF);
    queue_render(8'd159, 5'd15, 1'b0);
    // row start past the end of the memory
    queue_render(8'd160, 5'd0, 1'b0);
    queue_render(8'd255, 5'd15, 1'b0);
    wait_drained();

    // random phases, each under its own register setting, extremes first
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin wv = 5'd1;  hv = 6'd1;  end
        1:       begin wv = 5'd23; hv = 6'd32; end
        2:       begin wv = 5'd0;  hv = 6'd0;  end
        3:       begin wv = 5'd31; hv = 6'd63; end
        4:       begin wv = 5'd16; hv = 6'd33; end
        5:       begin wv = 5'd9;  hv = 6'd5;  end
        6:       begin wv = 5'd7;  hv = 6'd31; end
        default: begin wv = 5'($urandom_range(23, 1)); hv = 6'($urandom_range(32, 1)); end
      endcase
      case (ph)
        0:       begin fgv = 16'h0000; bgv = 16'hFFFF; end
        1:       begin fgv = 16'hFFFF; bgv = 16'h0000; end
        default: begin fgv = 16'($urandom); bgv = 16'($urandom); end
      endcase
      // unused upper data bits sometimes carry junk
      if ($urandom_range(1))
        write_reg(REG_FONT_WIDTH, (CFG_DW'($urandom) & 16'hFFE0) | CFG_DW'(wv));
      else
        write_reg(REG_FONT_WIDTH, CFG_DW'(wv));
      if ($urandom_range(1))
        write_reg(REG_FONT_HEIGHT, (CFG_DW'($urandom) & 16'hFFC0) | CFG_DW'(hv));
      else
        write_reg(REG_FONT_HEIGHT, CFG_DW'(hv));
      write_reg(REG_FG_COLOUR, fgv);
      write_reg(REG_BG_COLOUR, bgv);
      settings_used++;

      // vary pressure; some phases run flat out, the last one has no idling
      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 20; recv_stall_pct = 10; end
        2:       begin send_idle_pct = 5;  recv_stall_pct = 40; end
        default: begin send_idle_pct = 40; recv_stall_pct = 20; end
      endcase
      if (ph == PHASES - 1) calm_tail = 1'b1;

      queue_random_mix(MIX_PER_PHASE);
      wait_drained();
    end

    $display("%0d render requests (%0d rejected) and %0d font loads, %0d pixels checked",
             render_count, rejected_rows, load_count, pixels_checked);
    $display("%0d register settings, widths 0 to 31 and heights 0 to 63 among them",
             settings_used);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[glyph_row_pixel_expander.f]
+incdir+design
design/gpx_pkg.sv
design/glyph_row_pixel_expander.sv
design/gpx_checker.sv
tb/glyph_row_pixel_expander_tb.sv
